[hw/rtl/srp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types, register indexes and the reset bin size for the skyline rectangle packer.
// ----------------------------------------------------------------------------
package srp_pkg;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SRCH  = 5'b00010,
		S_COPY  = 5'b00100,
		S_FLUSH = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	localparam logic REG_BIN_WIDTH  = 1'b0;
	localparam logic REG_BIN_HEIGHT = 1'b1;

	localparam logic [12:0] BIN_RESET = 13'd1024;

endpackage

[hw/rtl/skyline_rect_packer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skyline_rect_packer
// Bottom-left skyline packer: segments live in one ping-pong memory, a search
// walk finds the lowest fit, and a copy pass rebuilds the list into the other half.
// ----------------------------------------------------------------------------
// The idle state accepts a request, then the search reads one segment per cycle, one for every
// start segment plus one for every further segment its span covers; a zero-sized request or
// a full store skips the search.
// A placement then copies the list into the other half and the flush state writes the last segment;
// the done state registers the result, waiting while the previous word is still held.
// One word is in work at a time; reset sets both sizes to 1024 and the skyline to one segment.
module skyline_rect_packer
	import srp_pkg::*;
#(
	parameter int MAX_SEGMENTS = 64,
	parameter int COORD_BITS   = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rect_valid,
	output logic        rect_ready,
	input  logic [12:0] rect_width,
	input  logic [12:0] rect_height,
	output logic        place_valid,
	input  logic        place_ready,
	output logic [11:0] place_x,
	output logic [11:0] place_y,
	output logic        placed,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int CW    = COORD_BITS;
	localparam int WB    = ((CW > 13) ? CW : 13) + 1;
	localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CNW   = $clog2(MAX_SEGMENTS + 1);
	localparam int DEPTH = 2 * (2 ** AW);
	localparam logic [WB-1:0] CMASK = WB'((64'd1 << CW) - 64'd1);
	localparam logic [CNW-1:0] MAXC = CNW'(MAX_SEGMENTS);

	logic [3*CW-1:0] mem [DEPTH];

	state_t state_q;
	logic [12:0] bin_w_q, bin_h_q, req_w_q, req_h_q;
	logic init_q, bank_q;
	logic [CNW-1:0] cnt_q, wcnt_q;

	logic [3*CW-1:0] rd_data_s1;
	logic rd_init_s1, rd_ok_q;
	logic [AW-1:0] idx_q, start_q, best_i_q;
	logic first_q, found_q;
	logic [WB-1:0] left_q, top_q, sx_q, sw_q;
	logic [WB-1:0] best_top_q, best_w_q, best_x_q, best_y_q;
	logic ins_done_q, trim_q;
	logic [WB-1:0] end_q;
	logic acc_vld_q;
	logic [CW-1:0] acc_x_q, acc_y_q, acc_w_q;
	logic [11:0] res_x_q, res_y_q;
	logic res_p_q;
	logic out_vld_q;
	logic [11:0] out_x_q, out_y_q;
	logic out_p_q;

	logic rd_en;
	logic [AW-1:0] rd_idx;
	logic wr_en;
	logic [AW-1:0] wr_idx;
	logic [3*CW-1:0] wr_data;

	logic [WB-1:0] d_x, d_y, d_w, reqw_m;
	logic [WB-1:0] st_top, left_in, left_nx, cand_top, cand_sw, cand_x, cut;
	logic x_fail, h_fail, run_off, s_fail, s_ok, s_fin, better, last_idx, last_start;
	logic push;
	logic [CW-1:0] push_x, push_y, push_w;

	assign rect_ready  = (state_q == S_IDLE);
	assign place_valid = out_vld_q;
	assign place_x     = out_x_q;
	assign place_y     = out_y_q;
	assign placed      = out_p_q;

	always_comb begin
		logic [WB-1:0] bw_m;
		bw_m = WB'(bin_w_q) & CMASK;
		if (rd_init_s1) begin
			d_x = '0;
			d_y = '0;
			d_w = bw_m;
		end else begin
			d_x = WB'(rd_data_s1[3*CW-1:2*CW]);
			d_y = WB'(rd_data_s1[2*CW-1:CW]);
			d_w = WB'(rd_data_s1[CW-1:0]);
		end
	end

	// One step of the span walk for the segment whose word just came back.
	always_comb begin
		reqw_m     = WB'(req_w_q) & CMASK;
		st_top     = (first_q || d_y > top_q) ? d_y : top_q;
		x_fail     = first_q && ((d_x + WB'(req_w_q)) > WB'(bin_w_q));
		h_fail     = (st_top + WB'(req_h_q)) > WB'(bin_h_q);
		left_in    = first_q ? WB'(req_w_q) : left_q;
		left_nx    = (d_w >= left_in) ? '0 : left_in - d_w;
		last_idx   = (CNW'(idx_q) + CNW'(1)) >= cnt_q;
		last_start = (CNW'(start_q) + CNW'(1)) >= cnt_q;
		run_off    = (left_nx != '0) && last_idx;
		s_fail     = x_fail || h_fail || run_off;
		s_ok       = !s_fail && (left_nx == '0);
		s_fin      = s_fail || s_ok;
		cand_top   = st_top + WB'(req_h_q);
		cand_sw    = first_q ? d_w : sw_q;
		cand_x     = first_q ? d_x : sx_q;
		better     = !found_q || (cand_top < best_top_q) ||
			((cand_top == best_top_q) && (cand_sw < best_w_q));
		cut        = end_q - d_x;
	end

	// Read issue, copy-pass stream into the merge accumulator, and the write port.
	always_comb begin
		rd_en   = 1'b0;
		rd_idx  = '0;
		push    = 1'b0;
		push_x  = d_x[CW-1:0];
		push_y  = d_y[CW-1:0];
		push_w  = d_w[CW-1:0];
		wr_en   = 1'b0;
		wr_idx  = wcnt_q[AW-1:0];
		wr_data = {acc_x_q, acc_y_q, acc_w_q};
		unique case (state_q)
			S_IDLE: begin
				rd_en = rect_valid && (rect_width != '0) && (rect_height != '0) &&
					(cnt_q < MAXC);
			end
			S_SRCH: begin
				if (rd_ok_q) begin
					if (!s_fin) begin
						rd_en  = 1'b1;
						rd_idx = idx_q + AW'(1);
					end else if (!last_start) begin
						rd_en  = 1'b1;
						rd_idx = start_q + AW'(1);
					end else if (found_q || (s_ok && better)) begin
						rd_en  = 1'b1;
						rd_idx = '0;
					end
				end
			end
			S_COPY: begin
				if (rd_ok_q) begin
					if (idx_q == best_i_q && !ins_done_q) begin
						push   = 1'b1;
						push_x = best_x_q[CW-1:0];
						push_y = best_top_q[CW-1:0];
						push_w = reqw_m[CW-1:0];
						rd_en  = 1'b1;
						rd_idx = idx_q;
					end else begin
						if (!trim_q || d_x >= end_q) begin
							push = 1'b1;
						end else if (d_w > cut) begin
							push   = 1'b1;
							push_x = d_x[CW-1:0] + cut[CW-1:0];
							push_w = d_w[CW-1:0] - cut[CW-1:0];
						end
						if (!last_idx) begin
							rd_en  = 1'b1;
							rd_idx = idx_q + AW'(1);
						end
					end
					if (push && acc_vld_q && (acc_y_q != push_y)) begin
						wr_en = 1'b1;
					end
				end
			end
			S_FLUSH: begin
				wr_en = 1'b1;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[{bank_q, rd_idx}];
		end
		rd_init_s1 <= init_q && (rd_idx == '0);
		if (wr_en) begin
			mem[{~bank_q, wr_idx}] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			bin_w_q    <= BIN_RESET;
			bin_h_q    <= BIN_RESET;
			init_q     <= 1'b1;
			bank_q     <= 1'b0;
			cnt_q      <= CNW'(1);
			wcnt_q     <= '0;
			rd_ok_q    <= 1'b0;
			found_q    <= 1'b0;
			first_q    <= 1'b0;
			ins_done_q <= 1'b0;
			trim_q     <= 1'b0;
			acc_vld_q  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			rd_ok_q <= rd_en;
			// In the done state the output register is reloaded below instead.
			if (out_vld_q && place_ready && (state_q != S_DONE)) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						if (cfg_index == REG_BIN_WIDTH) begin
							bin_w_q <= cfg_data;
							init_q  <= 1'b1;
							cnt_q   <= CNW'(1);
						end else begin
							bin_h_q <= cfg_data;
						end
					end
					if (rect_valid) begin
						req_w_q <= rect_width;
						req_h_q <= rect_height;
						found_q <= 1'b0;
						first_q <= 1'b1;
						idx_q   <= '0;
						start_q <= '0;
						res_x_q <= '0;
						res_y_q <= '0;
						res_p_q <= 1'b0;
						state_q <= rd_en ? S_SRCH : S_DONE;
					end
				end
				S_SRCH: begin
					if (s_ok && better) begin
						found_q    <= 1'b1;
						best_top_q <= cand_top;
						best_w_q   <= cand_sw;
						best_x_q   <= cand_x;
						best_y_q   <= st_top;
						best_i_q   <= start_q;
					end
					if (first_q) begin
						sx_q <= d_x;
						sw_q <= d_w;
					end
					top_q  <= st_top;
					left_q <= left_nx;
					if (!s_fin) begin
						idx_q   <= idx_q + AW'(1);
						first_q <= 1'b0;
					end else if (!last_start) begin
						idx_q   <= start_q + AW'(1);
						start_q <= start_q + AW'(1);
						first_q <= 1'b1;
					end else if (rd_en) begin
						idx_q      <= '0;
						ins_done_q <= 1'b0;
						trim_q     <= 1'b0;
						acc_vld_q  <= 1'b0;
						wcnt_q     <= '0;
						state_q    <= S_COPY;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_COPY: begin
					if (!ins_done_q) begin
						end_q <= best_x_q + reqw_m;
					end
					if (idx_q == best_i_q && !ins_done_q) begin
						ins_done_q <= 1'b1;
						trim_q     <= 1'b1;
					end else begin
						if (trim_q && (d_x >= end_q || d_w > cut)) begin
							trim_q <= 1'b0;
						end
						if (last_idx) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
					if (push) begin
						acc_vld_q <= 1'b1;
						if (acc_vld_q && acc_y_q == push_y) begin
							acc_w_q <= acc_w_q + push_w;
						end else begin
							acc_x_q <= push_x;
							acc_y_q <= push_y;
							acc_w_q <= push_w;
							if (acc_vld_q) begin
								wcnt_q <= wcnt_q + CNW'(1);
							end
						end
					end
				end
				S_FLUSH: begin
					cnt_q   <= wcnt_q + CNW'(1);
					bank_q  <= ~bank_q;
					init_q  <= 1'b0;
					res_x_q <= best_x_q[11:0];
					res_y_q <= best_y_q[11:0];
					res_p_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_vld_q || place_ready) begin
						out_vld_q <= 1'b1;
						out_x_q   <= res_x_q;
						out_y_q   <= res_y_q;
						out_p_q   <= res_p_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The segment count stays between one and the store size.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (cnt_q <= MAXC))
		else $error("segment count out of range");

	// The search walk always has a word in flight.
	a_srch_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> rd_ok_q)
		else $error("search without pending read");

	// The flush always has a merged segment to write.
	a_flush_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> acc_vld_q)
		else $error("flush without segment");

	// A result only appears when leaving the done state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == S_DONE))
		else $error("result from wrong state");

endmodule
